// ----- design/c8core_pkg.sv -----
`default_nettype none
package c8core_pkg;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_EXEC  = 2'd1;
    localparam logic [1:0] MODE_PIXEL = 2'd2;
    localparam logic [1:0] MODE_VREG  = 2'd3;

    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_LD   = 4'h6;
    localparam logic [3:0] OP_ADD  = 4'h7;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_DRW  = 4'hD;
    localparam logic [3:0] VF_IDX  = 4'hF;
    localparam logic [7:0] LO_CLS  = 8'hE0;

    localparam logic [11:0] PC_RESET = 12'h200;

    // Memory port selector
    typedef enum logic [1:0] {
        t_MA_WRITE = 2'd0,
        t_MA_PC    = 2'd1,
        t_MA_PC1   = 2'd2,
        t_MA_SPR   = 2'd3
    } t_maddr_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic        mem_we;
        t_maddr_sel  mem_sel;
        logic        ld_hi;
        logic        ld_lo;
        logic        exec_simple;   // apply jump/LD/ADD/LDI/other; jump loads pc, others advance it
        logic        draw_start;    // latch origin, clear hit, row = 0
        logic        row_load;      // latch sprite byte, col = 0
        logic        fb_rd;         // issue frame read for current pixel
        logic        fb_wr;         // write back toggled pixel
        logic        col_inc;
        logic        row_inc;
        logic        draw_end;      // VF = hit, advance pc
        logic        clr_start;
        logic        clr_step;
        logic        clr_end;       // advance pc after clear
        logic        pix_rd;        // frame read for pixel request
        logic        res_load;      // capture result
        logic        res_vreg;      // result carries the addressed V register
        logic        res_pix;       // result carries the pixel bit
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [3:0] op;
        logic       is_cls;
        logic       row_done;      // all rows drawn
        logic       row_skip;      // current row off screen
        logic       col_last;
        logic       pix_on;        // current sprite bit lit and on screen
        logic       clr_last;
    } t_sts;

endpackage
`default_nettype wire

// ----- design/c8core_ram.sv -----
`default_nettype none
module c8core_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- design/c8core_ctrl.sv -----
`default_nettype none
module c8core_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire [1:0]            i_mode,
    input  wire                  i_res_free,
    input  c8core_pkg::t_sts     i_sts,
    output logic                 o_busy,
    output logic                 o_res_valid,
    output c8core_pkg::t_cmd     o_cmd
);
    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_FETCH1, S_FETCH2, S_DECODE, S_CLEAR,
        S_ROW_RD, S_ROW_LD, S_PIX, S_PIX_WB, S_DONE, S_PIXRD, S_RESULT
    } t_state;

    t_state r_state;

    always_comb begin
        o_cmd = '0;
        o_cmd.mem_sel = c8core_pkg::t_MA_PC;
        unique case (r_state)
            // sweep the frame to zero after reset
            S_INIT: o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_mode)
                        c8core_pkg::MODE_WRITE: begin
                            o_cmd.mem_we = 1'b1;
                            o_cmd.mem_sel = c8core_pkg::t_MA_WRITE;
                            o_cmd.res_load = 1'b1;
                        end
                        c8core_pkg::MODE_VREG: begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_vreg = 1'b1;
                        end
                        c8core_pkg::MODE_PIXEL: o_cmd.pix_rd = 1'b1;
                        c8core_pkg::MODE_EXEC: ;    // high byte read at pc
                    endcase
                end
            end
            S_FETCH1: begin
                o_cmd.mem_sel = c8core_pkg::t_MA_PC1;
                o_cmd.ld_hi = 1'b1;
            end
            S_FETCH2: o_cmd.ld_lo = 1'b1;
            S_DECODE: begin
                if (i_sts.op == c8core_pkg::OP_DRW) begin
                    o_cmd.draw_start = 1'b1;
                end else if (i_sts.is_cls) begin
                    o_cmd.clr_start = 1'b1;
                end else begin
                    o_cmd.exec_simple = 1'b1;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    o_cmd.clr_end = 1'b1;
                end
            end
            S_ROW_RD: begin
                o_cmd.mem_sel = c8core_pkg::t_MA_SPR;
                if (i_sts.row_done) begin
                    o_cmd.draw_end = 1'b1;
                end else if (i_sts.row_skip) begin
                    o_cmd.row_inc = 1'b1;
                end
            end
            S_ROW_LD: o_cmd.row_load = 1'b1;
            S_PIX: begin
                o_cmd.fb_rd = 1'b1;
                if (!i_sts.pix_on) begin
                    o_cmd.col_inc = 1'b1;
                    o_cmd.row_inc = i_sts.col_last;
                end
            end
            S_PIX_WB: begin
                o_cmd.fb_wr = 1'b1;
                o_cmd.col_inc = 1'b1;
                o_cmd.row_inc = i_sts.col_last;
            end
            S_DONE: o_cmd.res_load = 1'b1;
            S_PIXRD: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_pix = 1'b1;
            end
            S_RESULT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            unique case (r_state)
                S_INIT: if (i_sts.clr_last) r_state <= S_IDLE;
                S_IDLE: begin
                    if (i_start) begin
                        unique case (i_mode)
                            c8core_pkg::MODE_EXEC:  r_state <= S_FETCH1;
                            c8core_pkg::MODE_PIXEL: r_state <= S_PIXRD;
                            default:                r_state <= S_RESULT;
                        endcase
                    end
                end
                S_FETCH1: r_state <= S_FETCH2;
                S_FETCH2: r_state <= S_DECODE;
                S_DECODE: begin
                    if (i_sts.op == c8core_pkg::OP_DRW) r_state <= S_ROW_RD;
                    else if (i_sts.is_cls) r_state <= S_CLEAR;
                    else r_state <= S_DONE;
                end
                S_CLEAR:  if (i_sts.clr_last) r_state <= S_DONE;
                S_ROW_RD: begin
                    if (i_sts.row_done) r_state <= S_DONE;
                    else if (!i_sts.row_skip) r_state <= S_ROW_LD;
                end
                S_ROW_LD: r_state <= S_PIX;
                S_PIX: begin
                    if (i_sts.pix_on) r_state <= S_PIX_WB;
                    else if (i_sts.col_last) r_state <= S_ROW_RD;
                end
                S_PIX_WB: r_state <= i_sts.col_last ? S_ROW_RD : S_PIX;
                S_DONE:   r_state <= S_RESULT;
                S_PIXRD:  r_state <= S_RESULT;
                S_RESULT: if (i_res_free) r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_RESULT);
endmodule
`default_nettype wire

// ----- design/c8core_dp.sv -----
`default_nettype none
module c8core_dp #(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 32,
    parameter int MEMORY_BYTES  = 4096
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire [11:0]          i_address,
    input  wire [7:0]           i_data,
    input  wire [5:0]           i_pixel_x,
    input  wire [4:0]           i_pixel_y,
    input  c8core_pkg::t_cmd    i_cmd,
    output c8core_pkg::t_sts    o_sts,
    output logic [11:0]         o_program_counter,
    output logic [11:0]         o_index_value,
    output logic [7:0]          o_flag_value,
    output logic [7:0]          o_read_value
);
    localparam int AW = $clog2(MEMORY_BYTES);
    localparam int XW = $clog2(SCREEN_WIDTH);
    localparam int YW = $clog2(SCREEN_HEIGHT);
    localparam int FP = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int FW = $clog2(FP);

    logic [11:0] r_pc, r_i;
    logic [7:0]  r_v [16];
    logic [7:0]  r_hi, r_lo, r_bits;
    logic [3:0]  r_row;
    logic [2:0]  r_col;
    logic [7:0]  r_ox, r_oy;
    logic        r_hit;
    logic [FW-1:0] r_clr;
    logic        r_ron;

    logic [11:0] mem_a;
    logic [7:0]  mem_q;
    always_comb begin
        unique case (i_cmd.mem_sel)
            c8core_pkg::t_MA_WRITE: mem_a = i_address;
            c8core_pkg::t_MA_PC:    mem_a = r_pc;
            c8core_pkg::t_MA_PC1:   mem_a = r_pc + 12'd1;
            default:                mem_a = r_i + {8'd0, r_row};
        endcase
    end

    c8core_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
        .i_clk(i_clk), .i_we(i_cmd.mem_we), .i_waddr(mem_a[AW-1:0]), .i_wdata(i_data),
        .i_raddr(mem_a[AW-1:0]), .o_rdata(mem_q)
    );

    // pixel coordinates of current sprite bit
    logic [8:0] px, py;
    assign px = {1'b0, r_ox} + {6'd0, r_col};
    assign py = {1'b0, r_oy} + {5'd0, r_row};
    logic px_ok, py_ok;
    assign px_ok = px < 9'(SCREEN_WIDTH);
    assign py_ok = py < 9'(SCREEN_HEIGHT);

    // frame buffer: one port pair, cleared by a sweep of one entry per cycle
    logic          fb_we;
    logic [FW-1:0] fb_wa, fb_ra;
    logic          fb_wd, fb_q;
    logic [FW-1:0] draw_pos;
    assign draw_pos = FW'(py[YW-1:0]) * FW'(SCREEN_WIDTH) + FW'(px[XW-1:0]);
    logic rq_ok;
    assign rq_ok = ({2'b0, i_pixel_x} < 8'(SCREEN_WIDTH)) &&
                   ({2'b0, i_pixel_y} < 7'(SCREEN_HEIGHT));
    always_comb begin
        fb_ra = draw_pos;
        if (i_cmd.pix_rd) begin
            fb_ra = FW'(i_pixel_y) * FW'(SCREEN_WIDTH) + FW'(i_pixel_x);
        end
        fb_we = i_cmd.fb_wr || i_cmd.clr_step;
        fb_wa = i_cmd.clr_step ? r_clr : draw_pos;
        fb_wd = i_cmd.clr_step ? 1'b0 : ~fb_q;
    end

    c8core_ram #(.WIDTH(1), .DEPTH(FP)) u_fb (
        .i_clk(i_clk), .i_we(fb_we), .i_waddr(fb_wa), .i_wdata(fb_wd),
        .i_raddr(fb_ra), .o_rdata(fb_q)
    );

    logic bit_on;
    assign bit_on = r_bits[3'd7 - r_col];

    logic [3:0] op;
    assign op = r_hi[7:4];

    assign o_sts.op       = op;
    assign o_sts.is_cls   = (r_hi == 8'h00) && (r_lo == c8core_pkg::LO_CLS);
    assign o_sts.row_done = (r_row == r_lo[3:0]);
    assign o_sts.row_skip = !py_ok;
    assign o_sts.col_last = (r_col == 3'd7);
    assign o_sts.pix_on   = bit_on && px_ok;
    assign o_sts.clr_last = (r_clr == FW'(FP - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= c8core_pkg::PC_RESET;
            r_i <= '0;
            for (int k = 0; k < 16; k++) r_v[k] <= '0;
            r_clr <= '0;
        end else begin
            if (i_cmd.ld_hi) r_hi <= mem_q;
            if (i_cmd.ld_lo) r_lo <= mem_q;
            if (i_cmd.exec_simple) begin
                r_pc <= (op == c8core_pkg::OP_JP) ? {r_hi[3:0], r_lo} : r_pc + 12'd2;
                unique case (op)
                    c8core_pkg::OP_LD:  r_v[r_hi[3:0]] <= r_lo;
                    c8core_pkg::OP_ADD: r_v[r_hi[3:0]] <= r_v[r_hi[3:0]] + r_lo;
                    c8core_pkg::OP_LDI: r_i <= {r_hi[3:0], r_lo};
                    default: ;
                endcase
            end
            if (i_cmd.draw_start) begin
                r_ox <= r_v[r_hi[3:0]];
                r_oy <= r_v[r_lo[7:4]];
                r_hit <= 1'b0;
                r_row <= '0;
            end
            if (i_cmd.row_load) begin
                r_bits <= mem_q;
                r_col <= '0;
            end
            if (i_cmd.fb_wr && fb_q) r_hit <= 1'b1;
            if (i_cmd.col_inc) r_col <= r_col + 3'd1;
            if (i_cmd.row_inc) r_row <= r_row + 4'd1;
            if (i_cmd.draw_end) begin
                r_v[c8core_pkg::VF_IDX] <= {7'd0, r_hit};
                r_pc <= r_pc + 12'd2;
            end
            if (i_cmd.clr_start) r_clr <= '0;
            if (i_cmd.clr_step) r_clr <= r_clr + FW'(1);
            if (i_cmd.clr_end) r_pc <= r_pc + 12'd2;
        end
    end

    // hold whether the requested pixel lies on screen until its bit returns
    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_rd) begin
            r_ron <= rq_ok;
        end
    end

    logic [7:0] rv;
    always_comb begin
        rv = '0;
        if (i_cmd.res_vreg) rv = r_v[i_address[3:0]];
        else if (i_cmd.res_pix) rv = {7'd0, fb_q & r_ron};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            o_program_counter <= r_pc;
            o_index_value     <= r_i;
            o_flag_value      <= r_v[c8core_pkg::VF_IDX];
            o_read_value      <= rv;
        end
    end
endmodule
`default_nettype wire

// ----- design/chip8_instruction_core.sv -----
// Channel  | Direction | Payload
// s_axis   | in        | tdata: mode[1:0] address[13:2] data[21:14] x[27:22] y[32:28]
// m_axis   | out       | tdata: pc[11:0] index[23:12] flag[31:24] read[39:32]
// One item at a time; steps from the accept cycle to the first result cycle:
// write and register read go straight to the result; pixel read adds one frame read; simple execute
// fetches both opcode bytes, decodes and executes; clear sweeps the frame, one entry zeroed per cycle;
// draw: each on-screen row takes a row fetch, a byte load and
// 8 pixels of read, with a toggle write for lit bits, on the one frame port; off-screen rows are skipped.
// Reset is synchronous, active low; V registers, I clear, pc = 0x200, then a
// sweep zeroes the frame while s_axis_tready stays low.
// The result holds on m_axis until taken; no new item is accepted meanwhile.
`default_nettype none
module chip8_instruction_core #(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 32,
    parameter int MEMORY_BYTES  = 4096
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [39:0]  s_axis_tdata,   // mode, address, data, pixel_x, pixel_y
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata    // program_counter, index_value, flag_value, read_value
);
    c8core_pkg::t_cmd cmd;
    c8core_pkg::t_sts sts;
    logic busy;
    logic [11:0] pc, iv;
    logic [7:0] fv, rv;

    assign s_axis_tready = !busy;

    c8core_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(s_axis_tvalid && !busy), .i_mode(s_axis_tdata[1:0]),
        .i_res_free(m_axis_tready), .i_sts(sts),
        .o_busy(busy), .o_res_valid(m_axis_tvalid), .o_cmd(cmd)
    );

    c8core_dp #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT),
                .MEMORY_BYTES(MEMORY_BYTES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_address(s_axis_tdata[13:2]),
        .i_data(s_axis_tdata[21:14]), .i_pixel_x(s_axis_tdata[27:22]),
        .i_pixel_y(s_axis_tdata[32:28]), .i_cmd(cmd), .o_sts(sts),
        .o_program_counter(pc), .o_index_value(iv), .o_flag_value(fv),
        .o_read_value(rv)
    );

    assign m_axis_tdata = {rv, fv, iv, pc};
endmodule
`default_nettype wire
